/* rtl/pse_pkg.sv */
// shared types, constants and codes of the polyline stroke expander
// no dependencies; imported by every module of the block
package pse_pkg;

    // coordinate and fraction widths
    localparam int COORD_W   = 32;
    localparam int FRAC_DEF  = 16;
    localparam int HW_W      = 31;

    // configuration port
    localparam int CFG_AW    = 5;
    localparam int CFG_DW    = 32;

    // shared multiplier and iterative unit
    localparam int MUL_W     = COORD_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ITER_W    = 64;
    localparam int CNT_W     = 5;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      last_vertex;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] mat_a;
        logic [COORD_W-1:0] mat_b;
        logic [COORD_W-1:0] mat_c;
        logic [COORD_W-1:0] mat_d;
        logic [COORD_W-1:0] shift_x;
        logic [COORD_W-1:0] shift_y;
        logic [HW_W-1:0]    half_width;
        logic               closed_loop;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_MAT_A, REG_MAT_B, REG_MAT_C, REG_MAT_D,
        REG_SHIFT_X, REG_SHIFT_Y, REG_HALF_WIDTH, REG_CLOSED_LOOP
    } t_reg_idx;

    typedef enum logic {
        OP_SQRT, OP_DIV
    } t_iter_op;

    typedef struct packed {
        logic     start;
        t_iter_op op;
    } t_iter_ctl;

    typedef enum logic [4:0] {
        S_IDLE, S_XF0, S_XF1, S_XF2, S_XF3, S_XF4,
        S_DIFF, S_NORM, S_SQ0, S_SQ1, S_SQ2, S_SQRT,
        S_MULHW, S_DIVST, S_DIV, S_OFS, S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_MAIN, PH_CLOSE, PH_CAP
    } t_phase;

endpackage

/* rtl/polyline_stroke_expander.sv */
// polyline stroke expander: points in, thick-line triangle strip vertices out
// depends on pse_pkg, pse_cfg, pse_mul and pse_iter
//
// Usage: points enter on the input channel (i_in_valid / o_in_stall), one
// transaction per point; strip vertices leave on the output channel
// (o_out_valid / i_out_stall). The affine transform, half width and loop
// mode are set through the apb-style port while the block is idle.
// A point is transformed through the shared multiplier. Each segment of
// nonzero length then takes a normalising shift, a bit-serial square root
// and two divisions before its vertex transactions (four, or two for the
// cap); a point gives 0 to 3 segments. The block takes one point at a
// time: o_in_stall is high until the last vertex of the point sits in
// the output register.
// A stalled output holds its vertex, and the sequencer waits on it.
// Reset clears the polyline state and restores the register defaults; no
// clearing pass is needed.
module polyline_stroke_expander #(
    parameter int FRAC_BITS = pse_pkg::FRAC_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  pse_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output pse_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pse_pkg::CFG_AW-1:0] paddr,
    input  logic [pse_pkg::CFG_DW-1:0] pwdata,
    output logic [pse_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import pse_pkg::*;

    t_cfg      w_cfg;
    t_state    r_state, n_state;
    t_phase    r_phase;
    logic [1:0] r_seen;
    logic      r_last;
    logic [COORD_W-1:0] r_px, r_py, r_tx;
    logic [COORD_W-1:0] r_prev_x, r_prev_y, r_first_x, r_first_y;
    logic [COORD_W-1:0] r_second_x, r_second_y;
    logic [COORD_W-1:0] r_sp_x, r_sp_y, r_sn_x, r_sn_y;
    logic [MUL_W-1:0]   r_ax, r_ay;
    logic      r_dxneg, r_dypos, r_div_y;
    logic [HW_W-1:0]    r_len, r_mx;
    logic [COORD_W-1:0] r_ox, r_oy;
    logic [1:0] r_vcnt;
    logic signed [PROD_W-1:0] r_acc;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic signed [MUL_W-1:0]  w_op_a, w_op_b;
    logic signed [PROD_W-1:0] w_prod, w_sum, w_shr;
    logic [COORD_W-1:0] w_xf;
    t_iter_ctl w_ictl;
    logic [ITER_W-1:0] w_inum;
    logic [HW_W-1:0]   w_ires;
    logic      w_idone;
    logic signed [MUL_W-1:0] w_dx, w_dy;
    logic [MUL_W-1:0] w_m;
    logic      w_accept, w_load, w_vend, w_final_ph, w_final;
    logic [COORD_W-1:0] w_vp_x, w_vp_y;

    pse_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(w_cfg)
    );

    pse_mul u_mul (
        .i_clk(i_clk), .i_op_a(w_op_a), .i_op_b(w_op_b), .o_prod(w_prod)
    );

    pse_iter u_iter (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ictl), .i_num(w_inum),
        .i_den(r_len), .o_result(w_ires), .o_done(w_idone)
    );

    // handshake
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_load      = !r_out_valid || !i_out_stall;

    // sum of two products, floored and translated
    assign w_sum = r_acc + w_prod;
    assign w_shr = w_sum >>> FRAC_BITS;
    assign w_xf  = w_shr[COORD_W-1:0] +
                   ((r_state == S_XF2) ? w_cfg.shift_x : w_cfg.shift_y);

    // segment difference and larger magnitude
    assign w_dx = $signed({r_sn_x[COORD_W-1], r_sn_x}) -
                  $signed({r_sp_x[COORD_W-1], r_sp_x});
    assign w_dy = $signed({r_sn_y[COORD_W-1], r_sn_y}) -
                  $signed({r_sp_y[COORD_W-1], r_sp_y});
    assign w_m  = (r_ax > r_ay) ? r_ax : r_ay;

    // vertex selection
    assign w_vend     = (r_phase == PH_CAP) ? (r_vcnt == 2'd1) : (r_vcnt == 2'd3);
    assign w_final_ph = (r_last && w_cfg.closed_loop) ? (r_phase == PH_CAP)
                                                      : (r_phase == PH_MAIN);
    assign w_final    = w_vend && w_final_ph;
    assign w_vp_x     = r_vcnt[1] ? r_sn_x : r_sp_x;
    assign w_vp_y     = r_vcnt[1] ? r_sn_y : r_sp_y;

    // shared multiplier operands and iterative unit control
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        w_ictl = '{start: 1'b0, op: OP_SQRT};
        w_inum = w_sum[ITER_W-1:0];
        case (r_state)
            S_XF0: begin
                w_op_a = $signed({w_cfg.mat_a[COORD_W-1], w_cfg.mat_a});
                w_op_b = $signed({r_px[COORD_W-1], r_px});
            end
            S_XF1: begin
                w_op_a = $signed({w_cfg.mat_b[COORD_W-1], w_cfg.mat_b});
                w_op_b = $signed({r_py[COORD_W-1], r_py});
            end
            S_XF2: begin
                w_op_a = $signed({w_cfg.mat_c[COORD_W-1], w_cfg.mat_c});
                w_op_b = $signed({r_px[COORD_W-1], r_px});
            end
            S_XF3: begin
                w_op_a = $signed({w_cfg.mat_d[COORD_W-1], w_cfg.mat_d});
                w_op_b = $signed({r_py[COORD_W-1], r_py});
            end
            S_SQ0: begin
                w_op_a = $signed(r_ax);
                w_op_b = $signed(r_ax);
            end
            S_SQ1: begin
                w_op_a = $signed(r_ay);
                w_op_b = $signed(r_ay);
            end
            S_SQ2: begin
                w_ictl = '{start: 1'b1, op: OP_SQRT};
            end
            S_MULHW: begin
                w_op_a = $signed(r_div_y ? r_ax : r_ay);
                w_op_b = $signed({{(MUL_W-HW_W){1'b0}}, w_cfg.half_width});
            end
            S_DIVST: begin
                w_ictl = '{start: 1'b1, op: OP_DIV};
                w_inum = w_prod[ITER_W-1:0] + ITER_W'(r_len >> 1);
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_XF0;
            S_XF0:   n_state = S_XF1;
            S_XF1:   n_state = S_XF2;
            S_XF2:   n_state = S_XF3;
            S_XF3:   n_state = S_XF4;
            S_XF4:   n_state = (r_seen == 2'd0) ? S_IDLE : S_DIFF;
            S_DIFF:  n_state = (w_dx == '0 && w_dy == '0) ? S_EMIT : S_NORM;
            S_NORM:  if (w_m[MUL_W-1:30] == '0 && w_m[29]) n_state = S_SQ0;
            S_SQ0:   n_state = S_SQ1;
            S_SQ1:   n_state = S_SQ2;
            S_SQ2:   n_state = S_SQRT;
            S_SQRT:  if (w_idone) n_state = S_MULHW;
            S_MULHW: n_state = S_DIVST;
            S_DIVST: n_state = S_DIV;
            S_DIV:   if (w_idone) n_state = r_div_y ? S_OFS : S_MULHW;
            S_OFS:   n_state = S_EMIT;
            S_EMIT: begin
                if (w_load && w_vend) begin
                    n_state = w_final_ph ? S_IDLE : S_DIFF;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_XF4) begin
                if (r_last) begin
                    r_seen <= 2'd0;
                end else begin
                    r_seen <= (r_seen == 2'd0) ? 2'd1 : 2'd2;
                end
            end
            if (r_state == S_EMIT && w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // polyline point store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_first_x  <= '0;
            r_first_y  <= '0;
            r_second_x <= '0;
            r_second_y <= '0;
        end else if (r_state == S_XF4) begin
            r_prev_x <= r_tx;
            r_prev_y <= w_xf;
            if (r_seen == 2'd0) begin
                r_first_x <= r_tx;
                r_first_y <= w_xf;
            end
            if (r_seen == 2'd1) begin
                r_second_x <= r_tx;
                r_second_y <= w_xf;
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_px   <= i_in_data.point_x;
                    r_py   <= i_in_data.point_y;
                    r_last <= i_in_data.last_point;
                end
            end
            S_XF1, S_XF3, S_SQ1: r_acc <= w_prod;
            S_XF2: r_tx <= w_xf;
            S_XF4: begin
                r_sp_x  <= r_prev_x;
                r_sp_y  <= r_prev_y;
                r_sn_x  <= r_tx;
                r_sn_y  <= w_xf;
                r_phase <= PH_MAIN;
            end
            S_DIFF: begin
                r_ax    <= w_dx[MUL_W-1] ? MUL_W'(-w_dx) : MUL_W'(w_dx);
                r_ay    <= w_dy[MUL_W-1] ? MUL_W'(-w_dy) : MUL_W'(w_dy);
                r_dxneg <= w_dx[MUL_W-1];
                r_dypos <= !w_dy[MUL_W-1] && (w_dy != '0);
                r_vcnt  <= 2'd0;
                r_ox    <= '0;
                r_oy    <= '0;
            end
            S_NORM: begin
                // larger magnitude into [2^29, 2^30)
                if (w_m[MUL_W-1:30] != '0) begin
                    r_ax <= r_ax >> 1;
                    r_ay <= r_ay >> 1;
                end else if (!w_m[29]) begin
                    r_ax <= r_ax << 1;
                    r_ay <= r_ay << 1;
                end
            end
            S_SQRT: begin
                if (w_idone) begin
                    r_len   <= w_ires;
                    r_div_y <= 1'b0;
                end
            end
            S_DIV: begin
                if (w_idone && !r_div_y) begin
                    r_mx    <= w_ires;
                    r_div_y <= 1'b1;
                end
            end
            S_OFS: begin
                r_ox <= r_dypos ? -COORD_W'(r_mx) : COORD_W'(r_mx);
                r_oy <= r_dxneg ? -COORD_W'(w_ires) : COORD_W'(w_ires);
            end
            S_EMIT: begin
                if (w_load) begin
                    r_out_data.vertex_x    <= r_vcnt[0] ? w_vp_x + r_ox : w_vp_x - r_ox;
                    r_out_data.vertex_y    <= r_vcnt[0] ? w_vp_y + r_oy : w_vp_y - r_oy;
                    r_out_data.last_vertex <= r_last && w_final;
                    r_vcnt <= r_vcnt + 2'd1;
                    // move on to the closing segment, then the cap
                    if (w_vend && r_phase == PH_MAIN) begin
                        r_phase <= PH_CLOSE;
                        r_sp_x  <= r_sn_x;
                        r_sp_y  <= r_sn_y;
                        r_sn_x  <= r_first_x;
                        r_sn_y  <= r_first_y;
                    end else if (w_vend && r_phase == PH_CLOSE) begin
                        r_phase <= PH_CAP;
                        r_sp_x  <= r_first_x;
                        r_sp_y  <= r_first_y;
                        r_sn_x  <= r_second_x;
                        r_sn_y  <= r_second_y;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/pse_cfg.sv */
// configuration register file behind the apb-style port
// depends on pse_pkg
module pse_cfg #(
    parameter int FRAC_BITS = pse_pkg::FRAC_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pse_pkg::CFG_AW-1:0] paddr,
    input  logic [pse_pkg::CFG_DW-1:0] pwdata,
    output logic [pse_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output pse_pkg::t_cfg              o_cfg
);
    import pse_pkg::*;

    localparam logic [COORD_W-1:0] ONE = COORD_W'(1) << FRAC_BITS;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mat_a       <= ONE;
            r_cfg.mat_b       <= '0;
            r_cfg.mat_c       <= '0;
            r_cfg.mat_d       <= ONE;
            r_cfg.shift_x     <= '0;
            r_cfg.shift_y     <= '0;
            r_cfg.half_width  <= ONE[HW_W-1:0];
            r_cfg.closed_loop <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_MAT_A:       r_cfg.mat_a       <= pwdata[COORD_W-1:0];
                REG_MAT_B:       r_cfg.mat_b       <= pwdata[COORD_W-1:0];
                REG_MAT_C:       r_cfg.mat_c       <= pwdata[COORD_W-1:0];
                REG_MAT_D:       r_cfg.mat_d       <= pwdata[COORD_W-1:0];
                REG_SHIFT_X:     r_cfg.shift_x     <= pwdata[COORD_W-1:0];
                REG_SHIFT_Y:     r_cfg.shift_y     <= pwdata[COORD_W-1:0];
                REG_HALF_WIDTH:  r_cfg.half_width  <= pwdata[HW_W-1:0];
                REG_CLOSED_LOOP: r_cfg.closed_loop <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_MAT_A:       prdata = r_cfg.mat_a;
            REG_MAT_B:       prdata = r_cfg.mat_b;
            REG_MAT_C:       prdata = r_cfg.mat_c;
            REG_MAT_D:       prdata = r_cfg.mat_d;
            REG_SHIFT_X:     prdata = r_cfg.shift_x;
            REG_SHIFT_Y:     prdata = r_cfg.shift_y;
            REG_HALF_WIDTH:  prdata = {1'b0, r_cfg.half_width};
            REG_CLOSED_LOOP: prdata = {31'b0, r_cfg.closed_loop};
            default:         prdata = '0;
        endcase
    end

endmodule

/* rtl/pse_mul.sv */
// shared signed multiplier with registered product
// depends on pse_pkg
module pse_mul (
    input  logic                             i_clk,
    input  logic signed [pse_pkg::MUL_W-1:0] i_op_a,
    input  logic signed [pse_pkg::MUL_W-1:0] i_op_b,
    output logic signed [pse_pkg::PROD_W-1:0] o_prod
);
    import pse_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule

/* rtl/pse_iter.sv */
// bit-serial unit: integer square root and restoring division
// depends on pse_pkg; one compare and subtract per cycle
module pse_iter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pse_pkg::t_iter_ctl         i_ctl,
    input  logic [pse_pkg::ITER_W-1:0] i_num,
    input  logic [pse_pkg::HW_W-1:0]   i_den,
    output logic [pse_pkg::HW_W-1:0]   o_result,
    output logic                       o_done
);
    import pse_pkg::*;

    localparam logic [ITER_W-1:0] SQRT_BIT0 = ITER_W'(1) << (ITER_W - 2);

    logic              r_busy, r_done;
    t_iter_op          r_op;
    logic [CNT_W-1:0]  r_cnt;
    logic [ITER_W-1:0] r_rem, r_root, r_bit;
    logic [HW_W-1:0]   r_q;
    logic [ITER_W-1:0] w_try;
    logic              w_ge;

    // shared trial value and compare
    assign w_try = (r_op == OP_SQRT) ? r_root + r_bit : r_bit;
    assign w_ge  = r_rem >= w_try;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op  <= i_ctl.op;
            r_rem <= i_num;
            r_root <= '0;
            r_q   <= '0;
            if (i_ctl.op == OP_SQRT) begin
                r_bit <= SQRT_BIT0;
                r_cnt <= CNT_W'(ITER_W / 2 - 1);
            end else begin
                r_bit <= {3'b0, i_den, 30'b0};
                r_cnt <= CNT_W'(HW_W - 1);
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (w_ge) begin
                r_rem <= r_rem - w_try;
            end
            if (r_op == OP_SQRT) begin
                r_root <= w_ge ? (r_root >> 1) + r_bit : r_root >> 1;
                r_bit  <= r_bit >> 2;
            end else begin
                r_q   <= {r_q[HW_W-2:0], w_ge};
                r_bit <= r_bit >> 1;
            end
        end
    end

    assign o_result = (r_op == OP_SQRT) ? r_root[HW_W-1:0] : r_q;
    assign o_done   = r_done;

endmodule

/* tb/tb_top.sv */
// self-checking testbench for polyline_stroke_expander: random polylines under several configs
// depends on pse_pkg and the rtl of the block; a scoreboard class predicts every strip vertex
`timescale 1ns / 100ps

module tb_top;
    import pse_pkg::*;

    localparam int FRAC = FRAC_DEF;

    // scoreboard: own copy of registers and polyline state, queue of expected vertices
    class stroke_scoreboard;
        t_cfg        cfg;
        logic [31:0] prev_x, prev_y, first_x, first_y, second_x, second_y;
        int          points_seen;
        t_out_item   vertex_q[$];
        int          errors;
        int          vertices_ok;
        int          points_in;

        function new();
            cfg = '0;
            cfg.mat_a = 32'h0001_0000;
            cfg.mat_d = 32'h0001_0000;
            cfg.half_width = 31'h0001_0000;
            {prev_x, prev_y, first_x, first_y, second_x, second_y} = '0;
            points_seen = 0;
            errors = 0;
            vertices_ok = 0;
            points_in = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_MAT_A:       cfg.mat_a = v;
                REG_MAT_B:       cfg.mat_b = v;
                REG_MAT_C:       cfg.mat_c = v;
                REG_MAT_D:       cfg.mat_d = v;
                REG_SHIFT_X:     cfg.shift_x = v;
                REG_SHIFT_Y:     cfg.shift_y = v;
                REG_HALF_WIDTH:  cfg.half_width = v[30:0];
                REG_CLOSED_LOOP: cfg.closed_loop = v[0];
                default: ;
            endcase
        endfunction

        function void report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endfunction

        // affine row: exact sum of products, floored, then wrapped shift
        function logic [31:0] affine(logic [31:0] ka, logic [31:0] kb, logic [31:0] sh,
                                     logic signed [31:0] x, logic signed [31:0] y);
            logic signed [127:0] a1, b1, x1, y1, acc;
            a1 = $signed(ka);
            b1 = $signed(kb);
            x1 = x;
            y1 = y;
            acc = a1 * x1 + b1 * y1;
            acc = acc >>> FRAC;
            return acc[31:0] + sh;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        // scaled unit normal of segment p->n; zero for a zero-length segment
        function void normal_offset(logic [31:0] px, logic [31:0] py, logic [31:0] nx,
                                    logic [31:0] ny, output longint ox, output longint oy);
            longint dx, dy;
            longint unsigned ax, ay, m, len, mx, my, hw;
            dx = longint'($signed(nx)) - longint'($signed(px));
            dy = longint'($signed(ny)) - longint'($signed(py));
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            ox = 0;
            oy = 0;
            if (ax == 0 && ay == 0) return;
            m = ax > ay ? ax : ay;
            while (m >= (64'd1 << 30)) begin
                ax >>= 1; ay >>= 1; m >>= 1;
            end
            while (m < (64'd1 << 29)) begin
                ax <<= 1; ay <<= 1; m <<= 1;
            end
            len = int_sqrt(ax * ax + ay * ay);
            hw = cfg.half_width;
            mx = (ay * hw + len / 2) / len;
            my = (ax * hw + len / 2) / len;
            ox = dy > 0 ? -longint'(mx) : longint'(mx);
            oy = dx < 0 ? -longint'(my) : longint'(my);
        endfunction

        function void push_vertex(logic [31:0] x, logic [31:0] y, longint ox, longint oy,
                                  bit plus);
            t_out_item v;
            logic [63:0] ux, uy;
            ux = ox;
            uy = oy;
            v.vertex_x = plus ? x + ux[31:0] : x - ux[31:0];
            v.vertex_y = plus ? y + uy[31:0] : y - uy[31:0];
            v.last_vertex = 1'b0;
            vertex_q.push_back(v);
        endfunction

        function void push_segment(logic [31:0] px, logic [31:0] py, logic [31:0] nx,
                                   logic [31:0] ny);
            longint ox, oy;
            normal_offset(px, py, nx, ny, ox, oy);
            push_vertex(px, py, ox, oy, 0);
            push_vertex(px, py, ox, oy, 1);
            push_vertex(nx, ny, ox, oy, 0);
            push_vertex(nx, ny, ox, oy, 1);
        endfunction

        // accepted point: transform it and queue the vertices it causes
        function void note_point(t_in_item p);
            logic [31:0] tx, ty;
            longint ox, oy;
            points_in++;
            tx = affine(cfg.mat_a, cfg.mat_b, cfg.shift_x, p.point_x, p.point_y);
            ty = affine(cfg.mat_c, cfg.mat_d, cfg.shift_y, p.point_x, p.point_y);
            if (points_seen == 0) begin
                first_x = tx;
                first_y = ty;
                points_seen = 1;
            end else begin
                if (points_seen == 1) begin
                    second_x = tx;
                    second_y = ty;
                end
                push_segment(prev_x, prev_y, tx, ty);
                points_seen = 2;
                if (p.last_point && cfg.closed_loop) begin
                    push_segment(tx, ty, first_x, first_y);
                    normal_offset(first_x, first_y, second_x, second_y, ox, oy);
                    push_vertex(first_x, first_y, ox, oy, 0);
                    push_vertex(first_x, first_y, ox, oy, 1);
                end
                if (p.last_point) vertex_q[$].last_vertex = 1'b1;
            end
            prev_x = tx;
            prev_y = ty;
            if (p.last_point) points_seen = 0;
        endfunction

        function void check(t_out_item got);
            t_out_item exp_v;
            if (vertex_q.size() == 0) begin
                report($sformatf("unexpected vertex %h", got));
                return;
            end
            exp_v = vertex_q.pop_front();
            if (got.vertex_x !== exp_v.vertex_x)
                report($sformatf("vertex_x %h, expected %h", got.vertex_x, exp_v.vertex_x));
            else if (got.vertex_y !== exp_v.vertex_y)
                report($sformatf("vertex_y %h, expected %h", got.vertex_y, exp_v.vertex_y));
            else if (got.last_vertex !== exp_v.last_vertex)
                report($sformatf("last_vertex %b, expected %b", got.last_vertex,
                                 exp_v.last_vertex));
            else
                vertices_ok++;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_item           i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_item          o_out_data;
    logic               psel, penable, pwrite;
    logic [CFG_AW-1:0]  paddr;
    logic [CFG_DW-1:0]  pwdata;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;

    stroke_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int configs_used   = 0;

    polyline_stroke_expander dut (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check(o_out_data);
    end

    // run limit
    initial begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_point(logic [31:0] x, logic [31:0] y, bit last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{point_x: x, point_y: y, last_point: last};
        do @(posedge i_clk); while (o_in_stall);
        sb.note_point(i_in_data);
    endtask

    // waits until every queued vertex has come out, then lets the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        wait (sb.vertex_q.size() == 0);
        repeat (600) @(posedge i_clk);
    endtask

    // apb write: setup then access cycle
    task automatic write_reg(t_reg_idx idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic write_all(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d,
                             logic [31:0] sx, logic [31:0] sy, logic [31:0] hw, bit cl);
        write_reg(REG_MAT_A, a);
        write_reg(REG_MAT_B, b);
        write_reg(REG_MAT_C, c);
        write_reg(REG_MAT_D, d);
        write_reg(REG_SHIFT_X, sx);
        write_reg(REG_SHIFT_Y, sy);
        write_reg(REG_HALF_WIDTH, hw);
        write_reg(REG_CLOSED_LOOP, {31'd0, cl});
        configs_used++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            default: return {{12{1'b0}}, 20'($urandom())} - 32'h0008_0000;
        endcase
    endfunction

    // random polylines: mostly well-formed with small coordinates, some full range
    task automatic random_polylines(int n_points);
        int len;
        int k;
        k = 0;
        while (k < n_points) begin
            len = $urandom_range(1, 5);
            for (int j = 0; j < len; j++) begin
                send_point(rand_coord(), rand_coord(), j == len - 1);
                k++;
            end
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset config, single point, extremes, zero-length segment
        send_point(32'h0001_0000, 32'h0002_0000, 1);
        send_point(32'h0000_0000, 32'h0000_0000, 0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 1);
        send_point(32'h8000_0000, 32'h7fff_ffff, 0);
        send_point(32'hffff_ffff, 32'h0000_0001, 1);
        send_point(32'h0005_0000, 32'h0005_0000, 0);
        send_point(32'h0005_0000, 32'h0005_0000, 1);
        drain();

        // directed: closed loop, triangle and degenerate two-point loop
        write_all(32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0010_0000, 32'hfff0_0000,
                  32'h0002_0000, 1);
        send_point(0, 0, 0);
        send_point(32'h0004_0000, 0, 0);
        send_point(0, 32'h0003_0000, 1);
        send_point(32'h0001_0000, 32'h0001_0000, 0);
        send_point(32'h0001_0000, 32'h0001_0000, 1);
        send_point(32'hffff_0000, 32'h0002_0000, 0);
        send_point(32'h0003_0000, 32'hfffe_0000, 1);

        // sender pauses until every vertex is out, mid-phase
        i_in_valid <= 1'b0;
        wait (sb.vertex_q.size() == 0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 1);
        drain();

        // extreme configs
        write_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1);
        send_point(32'h0001_0000, 32'hffff_0000, 0);
        send_point(32'h0000_8000, 32'h0002_0000, 0);
        send_point(32'hffff_ffff, 32'h8000_0000, 1);
        drain();
        write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 0);
        send_point(32'h0001_0000, 32'h0000_0001, 0);
        send_point(32'h7fff_ffff, 32'hffff_ffff, 1);
        drain();

        // random phases, each with its own idling mode and config
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            if (ph == 0)
                write_all(32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0);
            else
                write_all($urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
                          $urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
                          $urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
                          (ph == 5) ? $urandom() : $urandom_range(0, 32'h0002_0000),
                          $urandom(), $urandom(), $urandom(), $urandom_range(0, 1));
            // long receiver hold-off while points keep coming
            if (ph == 0 || ph == 4) hold_left = 400;
            random_polylines(13);
            drain();
        end

        $display("covered %0d points, %0d vertices matched, %0d register settings,",
                 sb.points_in, sb.vertices_ok, configs_used + 1);
        $display("open and closed polylines with sender gaps, receiver stalls and hold-offs");
        if (sb.errors == 0 && sb.vertex_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
